### hdl/camera_pose_translate_yaw_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the camera pose block
// Each check compares an antecedent at one clock edge with a consequent at the
// same edge (IMP) or at the next one (NEXT). Checks are left out in synthesis.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POSE_TRANSLATE_YAW_DEFINES_SVH
`define CAMERA_POSE_TRANSLATE_YAW_DEFINES_SVH
`ifndef SYNTHESIS
`define CPTYAW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("camera pose check failed");
`define CPTYAW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("camera pose check failed");
`else
`define CPTYAW_ASSERT_IMP(lbl, ante, cons)
`define CPTYAW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/cptyaw_pkg.sv
// ----------------------------------------------------------------------------
// cptyaw_pkg
// Constants, opcodes and the elaboration-time sine/cosine table builder for
// the camera pose block.
// ----------------------------------------------------------------------------
package cptyaw_pkg;

    // Default widths
    localparam int COORD_WIDTH    = 32;
    localparam int TRIG_FRAC_BITS = 15;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int AXIS_W    = 2;
    localparam int DELTA_W   = 32;
    localparam int ANGLE_W   = 10;
    localparam int OUT_W     = 32;

    // Widest supported coordinate and trig entry (sign + one + fraction)
    localparam int COORD_MAX_W = 48;
    localparam int TRIG_TAB_W  = 26;

    // Degree table
    localparam int DEG_FULL = 360;
    localparam int DEG_W    = $clog2(DEG_FULL);

    // Q16.16 one
    localparam longint COORD_ONE = 65536;

    // Opcodes and axis codes
    localparam logic [OP_W-1:0]   OP_MOVE   = 2'd0;
    localparam logic [OP_W-1:0]   OP_ROTATE = 2'd1;
    localparam logic [OP_W-1:0]   OP_HOME   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;

    typedef logic [TRIG_TAB_W-1:0] t_trig_tab [DEG_FULL];

    // Home coordinate: units of one, clipped to the positive coordinate range
    function automatic logic [COORD_MAX_W-1:0] home_coord(int units, int cw);
        longint v;
        longint mx;
        v  = longint'(units) * COORD_ONE;
        mx = (longint'(1) << (cw - 1)) - 1;
        if (v > mx) begin
            v = mx;
        end
        return COORD_MAX_W'(v);
    endfunction

    // First-octant sine or cosine of d degrees in Q30, eight Taylor terms
    function automatic logic [63:0] octant(int d, bit want_cos);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = 64'(d) * 64'd18740330;
        term = want_cos ? 64'd1073741824 : x;
        sum  = term;
        for (int k = 1; k < 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (k)
                1: term = want_cos ? term / 64'd2   : term / 64'd6;
                2: term = want_cos ? term / 64'd12  : term / 64'd20;
                3: term = want_cos ? term / 64'd30  : term / 64'd42;
                4: term = want_cos ? term / 64'd56  : term / 64'd72;
                5: term = want_cos ? term / 64'd90  : term / 64'd110;
                6: term = want_cos ? term / 64'd132 : term / 64'd156;
                default: term = want_cos ? term / 64'd182 : term / 64'd210;
            endcase
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Round Q30 to frac bits, halves up
    function automatic longint to_trig(logic [63:0] q30, int frac);
        logic [63:0] v;
        v = (q30 + (64'd1 << (29 - frac))) >> (30 - frac);
        return longint'(v);
    endfunction

    // Sine or cosine of r degrees, r in 0..89
    function automatic longint trig_quarter(int r, bit want_cos, int frac);
        if (r <= 45) begin
            return to_trig(octant(r, want_cos), frac);
        end
        return to_trig(octant(90 - r, !want_cos), frac);
    endfunction

    // Full table over whole degrees, built at elaboration
    function automatic t_trig_tab trig_table(int frac, bit want_cos);
        t_trig_tab tab;
        int        q;
        int        r;
        longint    sr;
        longint    cr;
        longint    sv;
        longint    cv;
        for (int a = 0; a < DEG_FULL; a++) begin
            q  = a / 90;
            r  = a % 90;
            sr = trig_quarter(r, 1'b0, frac);
            cr = trig_quarter(r, 1'b1, frac);
            case (q)
                0: begin sv = sr;  cv = cr;  end
                1: begin sv = cr;  cv = -sr; end
                2: begin sv = -sr; cv = -cr; end
                default: begin sv = -cr; cv = sr; end
            endcase
            tab[a] = want_cos ? TRIG_TAB_W'(cv) : TRIG_TAB_W'(sv);
        end
        return tab;
    endfunction

endpackage

### hdl/camera_pose_translate_yaw.sv
// ----------------------------------------------------------------------------
// camera_pose_translate_yaw
// Camera pose keeper: moves eye and look-at together, turns the view about the
// vertical axis through the eye, and returns to the home pose on request.
// ----------------------------------------------------------------------------
// Usage:
//   Command words come in on the input channel (i_in_valid / o_in_stall) and
//   each one yields exactly one result word on the output channel
//   (o_out_valid / i_out_stall): a success flag plus the full pose after the
//   command. Move adds the delta to eye and look-at, rotate about Y turns the
//   look-at point about the eye and turns the up vector, home restores the
//   initial pose. Rotation about X or Z changes nothing and reports ok = 0.
//   An accepted command passes through the input register (angle reduction and
//   sine/cosine table read happen in front of it) and then the pose update that
//   writes the pose and result registers. Throughput is one command per cycle
//   while the receiver does not stall; the pose registers themselves are the
//   result payload, so the next command updates the pose in the same cycle the
//   previous result word is taken.
//   Reset (synchronous, active low) loads the home pose and empties both
//   stages. While the receiver stalls, the result word and pose hold, and the
//   input register accepts one more command before o_in_stall rises.
// ----------------------------------------------------------------------------
`include "camera_pose_translate_yaw_defines.svh"

module camera_pose_translate_yaw #(
    parameter int COORD_WIDTH    = cptyaw_pkg::COORD_WIDTH,
    parameter int TRIG_FRAC_BITS = cptyaw_pkg::TRIG_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [cptyaw_pkg::OP_W-1:0]     i_opcode,
    input  logic signed [cptyaw_pkg::DELTA_W-1:0]  i_delta_x,
    input  logic signed [cptyaw_pkg::DELTA_W-1:0]  i_delta_y,
    input  logic signed [cptyaw_pkg::DELTA_W-1:0]  i_delta_z,
    input  logic        [cptyaw_pkg::AXIS_W-1:0]   i_rot_axis,
    input  logic signed [cptyaw_pkg::ANGLE_W-1:0]  i_angle_deg,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_ok,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_eye_x,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_eye_y,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_eye_z,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_look_x,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_look_y,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_look_z,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_upv_x,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_upv_y,
    output logic signed [cptyaw_pkg::OUT_W-1:0]    o_upv_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = TRIG_FRAC_BITS;
    localparam int TW  = FB + 2;                  // sign, one, fraction
    localparam int DW  = CW + 1;                  // coordinate difference
    localparam int PW  = DW + TW;                 // full product
    localparam int SW  = CW + 3;                  // rounded product and rotate sum
    localparam int MW  = ((CW > cptyaw_pkg::DELTA_W) ? CW : cptyaw_pkg::DELTA_W) + 1;
    localparam int XW  = (SW > MW) ? SW : MW;     // common width before clipping
    localparam int AEW = cptyaw_pkg::ANGLE_W + 1;
    localparam int DGW = cptyaw_pkg::DEG_W;

    localparam logic signed [PW-1:0] RND_UP = PW'(1) <<< (FB - 1);
    localparam logic signed [PW-1:0] RND_DN = RND_UP - PW'(1);
    localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (CW - 1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    localparam logic signed [AEW-1:0] DEG_ONE_TURN = AEW'(cptyaw_pkg::DEG_FULL);
    localparam logic signed [AEW-1:0] DEG_TWO_TURN = AEW'(2 * cptyaw_pkg::DEG_FULL);

    localparam logic [CW-1:0] HOME_FIVE = CW'(cptyaw_pkg::home_coord(5, CW));
    localparam logic [CW-1:0] HOME_ONE  = CW'(cptyaw_pkg::home_coord(1, CW));
    localparam logic [2:0][CW-1:0] HOME_EYE  = {HOME_FIVE, HOME_FIVE, CW'(0)};
    localparam logic [2:0][CW-1:0] HOME_LOOK = {CW'(0), HOME_FIVE, CW'(0)};
    localparam logic [2:0][CW-1:0] HOME_UP   = {CW'(0), HOME_ONE, CW'(0)};

    localparam cptyaw_pkg::t_trig_tab SIN_TAB = cptyaw_pkg::trig_table(FB, 1'b0);
    localparam cptyaw_pkg::t_trig_tab COS_TAB = cptyaw_pkg::trig_table(FB, 1'b1);

    // product rounded to the coordinate scale, halves away from zero
    function automatic logic signed [SW-1:0] mul_rnd(logic signed [DW-1:0] d,
                                                     logic signed [TW-1:0] t);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = d * t;
        q = p + (p[PW-1] ? RND_DN : RND_UP);
        return SW'(q >>> FB);
    endfunction

    // clip to the signed coordinate range
    function automatic logic [CW-1:0] sat_cw(logic signed [XW-1:0] v);
        if (v > SAT_HI) begin
            return CW'(SAT_HI);
        end
        if (v < SAT_LO) begin
            return CW'(SAT_LO);
        end
        return CW'(v);
    endfunction

    // low output bits of a stored coordinate, sign-extended when narrower
    function automatic logic [cptyaw_pkg::OUT_W-1:0] out_word(logic [CW-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[cptyaw_pkg::OUT_W-1:0];
    endfunction

    // handshake control
    logic                                 r_in_vld;
    logic                                 r_out_vld;
    logic                                 adv;
    logic                                 in_acc;

    // input register payload
    logic [cptyaw_pkg::OP_W-1:0]          r_op;
    logic [cptyaw_pkg::AXIS_W-1:0]        r_axis;
    logic [2:0][cptyaw_pkg::DELTA_W-1:0]  r_delta;
    logic signed [TW-1:0]                 r_sin;
    logic signed [TW-1:0]                 r_cos;

    // pose and result flag
    logic [2:0][CW-1:0]                   r_eye;
    logic [2:0][CW-1:0]                   r_look;
    logic [2:0][CW-1:0]                   r_up;
    logic                                 r_ok;
    logic [2:0][CW-1:0]                   n_eye;
    logic [2:0][CW-1:0]                   n_look;
    logic [2:0][CW-1:0]                   n_up;
    logic                                 n_ok;

    // angle reduction
    logic signed [AEW-1:0]                ang;
    logic signed [AEW-1:0]                ang_red;
    logic [DGW-1:0]                       deg_idx;

    // rotation operands and rounded products
    logic signed [DW-1:0]                 dx;
    logic signed [DW-1:0]                 dz;
    logic signed [DW-1:0]                 ux;
    logic signed [DW-1:0]                 uz;
    logic signed [SW-1:0]                 m_cdx;
    logic signed [SW-1:0]                 m_sdz;
    logic signed [SW-1:0]                 m_cdz;
    logic signed [SW-1:0]                 m_sdx;
    logic signed [SW-1:0]                 m_cux;
    logic signed [SW-1:0]                 m_suz;
    logic signed [SW-1:0]                 m_cuz;
    logic signed [SW-1:0]                 m_sux;

    // advance the update stage when the result slot is free or being taken
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // reduce the angle into 0..359
    assign ang = AEW'(i_angle_deg);
    always_comb begin
        if (ang >= DEG_ONE_TURN) begin
            ang_red = ang - DEG_ONE_TURN;
        end else if (ang >= 0) begin
            ang_red = ang;
        end else if (ang >= -DEG_ONE_TURN) begin
            ang_red = ang + DEG_ONE_TURN;
        end else begin
            ang_red = ang + DEG_TWO_TURN;
        end
    end
    assign deg_idx = ang_red[DGW-1:0];

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // capture the command word and its table entries
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_opcode;
            r_axis     <= i_rot_axis;
            r_delta[0] <= i_delta_x;
            r_delta[1] <= i_delta_y;
            r_delta[2] <= i_delta_z;
            r_sin      <= SIN_TAB[deg_idx][TW-1:0];
            r_cos      <= COS_TAB[deg_idx][TW-1:0];
        end
    end

    // rotation operands
    assign dx = DW'(signed'(r_look[0])) - DW'(signed'(r_eye[0]));
    assign dz = DW'(signed'(r_look[2])) - DW'(signed'(r_eye[2]));
    assign ux = DW'(signed'(r_up[0]));
    assign uz = DW'(signed'(r_up[2]));

    assign m_cdx = mul_rnd(dx, r_cos);
    assign m_sdz = mul_rnd(dz, r_sin);
    assign m_cdz = mul_rnd(dz, r_cos);
    assign m_sdx = mul_rnd(dx, r_sin);
    assign m_cux = mul_rnd(ux, r_cos);
    assign m_suz = mul_rnd(uz, r_sin);
    assign m_cuz = mul_rnd(uz, r_cos);
    assign m_sux = mul_rnd(ux, r_sin);

    // next pose per command
    always_comb begin
        n_eye  = r_eye;
        n_look = r_look;
        n_up   = r_up;
        n_ok   = 1'b0;
        unique case (r_op)
            cptyaw_pkg::OP_MOVE: begin
                for (int i = 0; i < 3; i++) begin
                    n_eye[i]  = sat_cw(XW'(signed'(r_eye[i])) + XW'(signed'(r_delta[i])));
                    n_look[i] = sat_cw(XW'(signed'(r_look[i])) + XW'(signed'(r_delta[i])));
                end
                n_ok = 1'b1;
            end
            cptyaw_pkg::OP_ROTATE: begin
                if (r_axis == cptyaw_pkg::AXIS_Y) begin
                    n_look[0] = sat_cw(XW'(signed'(r_eye[0])) + XW'(m_cdx) + XW'(m_sdz));
                    n_look[2] = sat_cw(XW'(signed'(r_eye[2])) + XW'(m_cdz) - XW'(m_sdx));
                    n_up[0]   = sat_cw(XW'(m_cux) + XW'(m_suz));
                    n_up[2]   = sat_cw(XW'(m_cuz) - XW'(m_sux));
                    n_ok      = 1'b1;
                end
            end
            cptyaw_pkg::OP_HOME: begin
                n_eye  = HOME_EYE;
                n_look = HOME_LOOK;
                n_up   = HOME_UP;
                n_ok   = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // pose registers double as the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye     <= HOME_EYE;
            r_look    <= HOME_LOOK;
            r_up      <= HOME_UP;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_eye     <= n_eye;
            r_look    <= n_look;
            r_up      <= n_up;
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // result flag
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok <= n_ok;
        end
    end

    // drive the result word
    assign o_out_valid = r_out_vld;
    assign o_ok        = r_ok;
    assign o_eye_x     = out_word(r_eye[0]);
    assign o_eye_y     = out_word(r_eye[1]);
    assign o_eye_z     = out_word(r_eye[2]);
    assign o_look_x    = out_word(r_look[0]);
    assign o_look_y    = out_word(r_look[1]);
    assign o_look_z    = out_word(r_look[2]);
    assign o_upv_x     = out_word(r_up[0]);
    assign o_upv_y     = out_word(r_up[1]);
    assign o_upv_z     = out_word(r_up[2]);

    // checks
    `CPTYAW_ASSERT_NEXT(a_home_pose, adv && (r_op == cptyaw_pkg::OP_HOME), (r_eye == HOME_EYE) && (r_look == HOME_LOOK) && (r_up == HOME_UP) && o_ok)
    `CPTYAW_ASSERT_NEXT(a_stall_holds_pose, r_out_vld && i_out_stall, $stable(r_eye) && $stable(r_look) && $stable(r_up))
    `CPTYAW_ASSERT_NEXT(a_yaw_keeps_y, adv && (r_op == cptyaw_pkg::OP_ROTATE), $stable(r_eye) && (r_look[1] == $past(r_look[1])) && (r_up[1] == $past(r_up[1])))
    `CPTYAW_ASSERT_NEXT(a_fail_no_change, adv && !n_ok, $stable(r_look) && $stable(r_up) && !o_ok)

endmodule
